// ----- rtl/core/frc_pkg.sv -----
package frc_pkg;

  localparam int unsigned HeightW  = 11;
  localparam int unsigned PenW     = 8;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned RowW     = 10;
  localparam int unsigned RootW    = 10;
  localparam int unsigned RadW     = 2 * RootW;
  localparam int unsigned NumCells = RootW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  localparam int unsigned MaxHeight = 1024;

  localparam logic [HeightW-1:0] HeightReset = HeightW'(16);
  localparam logic [PenW-1:0]    PenReset    = PenW'(3);

  // highest power of four that fits the radicand
  localparam logic [RadW-1:0] DigitInit = RadW'(1) << (RadW - 2);

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEIGHT = 2'd0,
    REG_PEN    = 2'd1
  } frc_reg_e;

  typedef struct packed {
    logic [RadW-1:0] num;
    logic [RadW-1:0] res;
    logic [RadW-1:0] digit;
  } frc_sq_t;

  typedef struct packed {
    logic busy;
    logic valid;
  } frc_prep_st_t;

  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] y_row;
    logic              sel;
  } frc_item_t;

endpackage

// ----- rtl/core/filled_circle_row_span.sv -----
// Filled circle row span.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 height, 1 pen)
// and cfg_data_i. cfg_ready_o is always high; write only while busy_o is low.
// A height above 1024 stores 16. Other indexes are ignored.
// Input: a row item (left_x_i, top_y_i, row_i, selected_i) is taken at a
// clock edge with start_i high and busy_o low.
// Output: valid_o marks the span for one cycle; there is no back-pressure.
// The strobe rises once a row has passed every stage; busy_o drops with it,
// so a new row is taken only once the last one has reached the output register.
// The pipeline is one input register, one squaring stage and a chain
// of 10 square-root cells, one root bit per cell, plus the output register.
// A row at or beyond the height is taken and gives no span;
// busy_o stays low.
// Reset: height 16, pen 3, nothing in flight, valid_o low.
module filled_circle_row_span (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [frc_pkg::CoordW-1:0]   left_x_i,
  input  logic signed [frc_pkg::CoordW-1:0]   top_y_i,
  input  logic [frc_pkg::RowW-1:0]            row_i,
  input  logic                                selected_i,
  output logic                                valid_o,
  output logic signed [frc_pkg::CoordW-1:0]   x_start_o,
  output logic signed [frc_pkg::CoordW-1:0]   x_end_o,
  output logic signed [frc_pkg::CoordW-1:0]   y_row_o,
  output logic [frc_pkg::PenW-1:0]            pen_out_o,
  output logic                                dithered_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [frc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [frc_pkg::CfgDataW-1:0]        cfg_data_i
);
  import frc_pkg::*;

  logic [HeightW-1:0] height;
  logic [PenW-1:0]    pen;
  logic               accept;
  frc_prep_st_t       prep_st;
  frc_item_t          item;
  logic [RadW-1:0]    rad2;

  frc_sq_t            chain [NumCells+1];
  logic [NumCells:0]  chain_v;

  logic               valid_q;
  logic [CoordW-1:0]  x_start_q, x_end_q, y_row_q;
  logic [PenW-1:0]    pen_q;
  logic               dith_q;
  logic [CoordW-1:0]  dx;

  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  frc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .height_o    (height),
    .pen_o       (pen)
  );

  frc_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .left_x_i   (left_x_i),
    .top_y_i    (top_y_i),
    .row_i      (row_i),
    .selected_i (selected_i),
    .height_i   (height),
    .status_o   (prep_st),
    .item_o     (item),
    .rad2_o     (rad2)
  );

  assign chain_v[0]     = prep_st.valid;
  assign chain[0].num   = rad2;
  assign chain[0].res   = '0;
  assign chain[0].digit = DigitInit;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    frc_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_v[g]),
      .data_i  (chain[g]),
      .valid_o (chain_v[g+1]),
      .data_o  (chain[g+1])
    );
  end

  assign busy_o = prep_st.busy | (|chain_v[NumCells:1]);
  assign dx     = CoordW'(chain[NumCells].res[RootW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= chain_v[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_v[NumCells]) begin
      x_start_q <= item.cx - dx;
      x_end_q   <= item.cx + dx;
      y_row_q   <= item.y_row;
      pen_q     <= pen;
      dith_q    <= item.sel;
    end
  end

  assign valid_o    = valid_q;
  assign x_start_o  = x_start_q;
  assign x_end_o    = x_end_q;
  assign y_row_o    = y_row_q;
  assign pen_out_o  = pen_q;
  assign dithered_o = dith_q;

endmodule

// ----- rtl/core/frc_cfg_regs.sv -----
module frc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [frc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [frc_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic [frc_pkg::HeightW-1:0]   height_o,
  output logic [frc_pkg::PenW-1:0]      pen_o
);
  import frc_pkg::*;

  logic [HeightW-1:0] height_q, height_d;
  logic [PenW-1:0]    pen_q, pen_d;

  always_comb begin
    height_d = height_q;
    pen_d    = pen_q;
    if (cfg_valid_i) begin
      unique case (frc_reg_e'(cfg_index_i))
        REG_HEIGHT: begin
          if (32'(cfg_data_i) > MaxHeight) begin
            height_d = HeightReset;
          end else begin
            height_d = HeightW'(cfg_data_i);
          end
        end
        REG_PEN: pen_d = cfg_data_i[PenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HeightReset;
      pen_q    <= PenReset;
    end else begin
      height_q <= height_d;
      pen_q    <= pen_d;
    end
  end

  assign height_o = height_q;
  assign pen_o    = pen_q;

endmodule

// ----- rtl/core/frc_prep.sv -----
module frc_prep (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [frc_pkg::CoordW-1:0]   left_x_i,
  input  logic [frc_pkg::CoordW-1:0]   top_y_i,
  input  logic [frc_pkg::RowW-1:0]     row_i,
  input  logic                         selected_i,
  input  logic [frc_pkg::HeightW-1:0]  height_i,
  output frc_pkg::frc_prep_st_t        status_o,
  output frc_pkg::frc_item_t           item_o,
  output logic [frc_pkg::RadW-1:0]     rad2_o
);
  import frc_pkg::*;

  logic               s0_valid_q, s1_valid_q;
  logic [CoordW-1:0]  left_q, top_q;
  logic [RowW-1:0]    row_q;
  logic               sel_q;
  logic [RootW-1:0]   r_q, yc_q;
  logic [RadW-1:0]    rr_q, yy_q;
  frc_item_t          item_q;

  logic               in_range;
  logic [HeightW:0]   h_inc;
  logic [RootW-1:0]   r_d, yc_d;

  assign in_range = HeightW'(row_i) < height_i;
  assign h_inc    = (HeightW+1)'(height_i) + (HeightW+1)'(1);
  assign r_d      = h_inc[RootW:1];
  assign yc_d     = (row_i >= r_d) ? (row_i - r_d) : (r_d - row_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= accept_i && in_range;
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      left_q <= left_x_i;
      top_q  <= top_y_i;
      row_q  <= row_i;
      sel_q  <= selected_i;
      r_q    <= r_d;
      yc_q   <= yc_d;
    end
    if (s0_valid_q) begin
      rr_q         <= RadW'(r_q) * RadW'(r_q);
      yy_q         <= RadW'(yc_q) * RadW'(yc_q);
      item_q.cx    <= left_q + CoordW'(r_q);
      item_q.y_row <= top_q + CoordW'(row_q);
      item_q.sel   <= sel_q;
    end
  end

  assign rad2_o          = (yy_q <= rr_q) ? (rr_q - yy_q) : '0;
  assign item_o          = item_q;
  assign status_o.valid  = s1_valid_q;
  assign status_o.busy   = s0_valid_q | s1_valid_q;

endmodule

// ----- rtl/core/frc_sqrt_cell.sv -----
module frc_sqrt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  frc_pkg::frc_sq_t  data_i,
  output logic              valid_o,
  output frc_pkg::frc_sq_t  data_o
);
  import frc_pkg::*;

  logic            valid_q;
  frc_sq_t         data_q, data_d;
  logic [RadW-1:0] trial;

  // one root bit per cell: restoring digit-by-digit step
  always_comb begin
    trial        = data_i.res + data_i.digit;
    data_d.digit = data_i.digit >> 2;
    if (data_i.num >= trial) begin
      data_d.num = data_i.num - trial;
      data_d.res = (data_i.res >> 1) + data_i.digit;
    end else begin
      data_d.num = data_i.num;
      data_d.res = data_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/core/frc_checker.sv -----
module frc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic valid_o
);

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("span strobe while a row is in flight");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("span strobe longer than one cycle");

  a_busy_ends_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> valid_o)
    else $error("row work ended without a span");

  a_no_early_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !valid_o)
    else $error("span right after a transfer");

endmodule

bind filled_circle_row_span frc_checker u_frc_checker (.*);

// ----- verif/tb_filled_circle_row_span.sv -----
module tb_filled_circle_row_span;
  import frc_pkg::*;

  localparam int SettleCycles  = 16;
  localparam int StallLimit    = 200;
  localparam int NumDir        = 33;
  localparam int NumPhases     = 12;
  localparam int SpansPerPhase = 146;

  localparam logic [CfgIdxW-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_B = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] x_start;
    logic signed [CoordW-1:0] x_end;
    logic signed [CoordW-1:0] y_row;
    logic [PenW-1:0]          pen;
    logic                     dith;
  } span_t;

  typedef enum logic [1:0] {EXP_MODEL, EXP_SPAN, EXP_NONE} exp_src_e;
  typedef enum logic {DIR_ROW, DIR_CFG} dir_op_e;

  typedef struct packed {
    dir_op_e              op;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic [CoordW-1:0]    left;
    logic [CoordW-1:0]    top;
    logic [RowW-1:0]      row;
    logic                 sel;
    exp_src_e             src;
    span_t                span;
  } dir_step_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic signed [CoordW-1:0]   left_x_i;
  logic signed [CoordW-1:0]   top_y_i;
  logic [RowW-1:0]            row_i;
  logic                       selected_i;
  logic                       valid_o;
  logic signed [CoordW-1:0]   x_start_o;
  logic signed [CoordW-1:0]   x_end_o;
  logic signed [CoordW-1:0]   y_row_o;
  logic [PenW-1:0]            pen_out_o;
  logic                       dithered_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CfgIdxW-1:0]         cfg_index_i;
  logic [CfgDataW-1:0]        cfg_data_i;

  exp_src_e                   exp_src;
  span_t                      exp_typed;

  logic [HeightW-1:0]         cfg_height = HeightReset;
  logic [PenW-1:0]            cfg_pen    = PenReset;
  span_t                      span_q[$];
  int                         n_errors     = 0;
  int                         stall_cycles = 0;
  dir_step_t                  dir_tbl [NumDir];

  filled_circle_row_span dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .left_x_i    (left_x_i),
    .top_y_i     (top_y_i),
    .row_i       (row_i),
    .selected_i  (selected_i),
    .valid_o     (valid_o),
    .x_start_o   (x_start_o),
    .x_end_o     (x_end_o),
    .y_row_o     (y_row_o),
    .pen_out_o   (pen_out_o),
    .dithered_o  (dithered_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic span_t predict_span(input logic [CoordW-1:0] left,
                                         input logic [CoordW-1:0] top,
                                         input logic [RowW-1:0] row,
                                         input logic sel,
                                         input logic [HeightW-1:0] h,
                                         input logic [PenW-1:0] pen);
    int unsigned radius, yc, rad, dx, trial;
    int b;
    span_t s;
    radius = (32'(h) + 1) >> 1;
    yc = (32'(row) >= radius) ? 32'(row) - radius : radius - 32'(row);
    rad = (yc * yc <= radius * radius) ? radius * radius - yc * yc : 0;
    // root bits from the top down
    dx = 0;
    for (b = RootW - 1; b >= 0; b--) begin
      trial = dx | (32'd1 << b);
      if (trial * trial <= rad) dx = trial;
    end
    s.x_start = CoordW'(32'(left) + radius - dx);
    s.x_end   = CoordW'(32'(left) + radius + dx);
    s.y_row   = CoordW'(32'(top) + 32'(row));
    s.pen     = pen;
    s.dith    = sel;
    return s;
  endfunction

  function automatic span_t mk_span(input logic [CoordW-1:0] xs, input logic [CoordW-1:0] xe,
                                    input logic [CoordW-1:0] y, input logic [PenW-1:0] pen,
                                    input logic dith);
    span_t s;
    s.x_start = xs;
    s.x_end   = xe;
    s.y_row   = y;
    s.pen     = pen;
    s.dith    = dith;
    return s;
  endfunction

  function automatic dir_step_t row_step(input exp_src_e src, input logic [CoordW-1:0] l,
                                         input logic [CoordW-1:0] t, input logic [RowW-1:0] r,
                                         input logic s, input span_t sp);
    dir_step_t d;
    d = '0;
    d.op   = DIR_ROW;
    d.left = l;
    d.top  = t;
    d.row  = r;
    d.sel  = s;
    d.src  = src;
    d.span = sp;
    return d;
  endfunction

  function automatic dir_step_t cfg_step(input logic [CfgIdxW-1:0] idx,
                                         input logic [CfgDataW-1:0] data);
    dir_step_t d;
    d = '0;
    d.op   = DIR_CFG;
    d.idx  = idx;
    d.data = data;
    d.src  = EXP_NONE;
    return d;
  endfunction

  function automatic int pick_gap(input int idle_pct);
    return ($urandom_range(0, 99) < idle_pct) ? int'($urandom_range(1, 11)) : 0;
  endfunction

  function automatic logic [CoordW-1:0] pick_coord();
    // bias toward the wrap point
    return ($urandom_range(0, 7) == 0) ? CoordW'(16'h7FF0 + $urandom_range(0, 31))
                                       : CoordW'($urandom);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    n_errors++;
  endtask

  task automatic send_row(input exp_src_e src, input logic [CoordW-1:0] l,
                          input logic [CoordW-1:0] t, input logic [RowW-1:0] r,
                          input logic s, input span_t typed, input int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    left_x_i   <= l;
    top_y_i    <= t;
    row_i      <= r;
    selected_i <= s;
    exp_src    <= src;
    exp_typed  <= typed;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    case (idx)
      REG_HEIGHT: cfg_height = (data > MaxHeight) ? HeightReset : data;
      REG_PEN:    cfg_pen = data[PenW-1:0];
      default: ;
    endcase
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_for_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (span_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : span_monitor
    span_t want;
    logic moved;
    moved = 1'b0;
    if (valid_o === 1'b1) begin
      moved = 1'b1;
      if (span_q.size() == 0) begin
        report_mismatch("span with none pending, x_start", x_start_o, 0);
      end else begin
        want = span_q.pop_front();
        if (x_start_o !== want.x_start) report_mismatch("x_start", x_start_o, want.x_start);
        if (x_end_o !== want.x_end) report_mismatch("x_end", x_end_o, want.x_end);
        if (y_row_o !== want.y_row) report_mismatch("y_row", y_row_o, want.y_row);
        if (pen_out_o !== want.pen) report_mismatch("pen_out", pen_out_o, want.pen);
        if (dithered_o !== want.dith) report_mismatch("dithered", dithered_o, want.dith);
      end
    end
    if (start_i === 1'b1 && busy_o === 1'b0) begin
      moved = 1'b1;
      case (exp_src)
        EXP_MODEL: begin
          if (row_i < cfg_height)
            span_q.push_back(predict_span(left_x_i, top_y_i, row_i, selected_i,
                                          cfg_height, cfg_pen));
        end
        EXP_SPAN: span_q.push_back(exp_typed);
        default: ;
      endcase
    end
    if (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1) moved = 1'b1;
    stall_cycles <= moved ? 0 : stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("%0t no transfer for %0d cycles", $time, StallLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int idle_pct;
    int sent;
    logic [RowW-1:0] row;
    logic [CfgDataW-1:0] h_data;
    logic [CfgDataW-1:0] pen_data;

    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    left_x_i    <= '0;
    top_y_i     <= '0;
    row_i       <= '0;
    selected_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    exp_src     <= EXP_NONE;
    exp_typed   <= '0;

    dir_tbl = '{
      // reset values: height 16, pen 3
      row_step(EXP_SPAN, 16'h0000, 16'h0000, 10'd0, 1'b0, mk_span(16'd8, 16'd8, 16'd0, 8'd3, 1'b0)),
      row_step(EXP_SPAN, 16'h0000, 16'h0000, 10'd8, 1'b1, mk_span(16'd0, 16'd16, 16'd8, 8'd3, 1'b1)),
      row_step(EXP_SPAN, 16'h0000, 16'h0000, 10'd15, 1'b0,
               mk_span(16'd5, 16'd11, 16'd15, 8'd3, 1'b0)),
      row_step(EXP_NONE, 16'h0000, 16'h0000, 10'd16, 1'b1, '0),
      row_step(EXP_NONE, 16'hFFFF, 16'hFFFF, 10'h3FF, 1'b1, '0),
      row_step(EXP_SPAN, 16'h7FFF, 16'h7FFF, 10'd8, 1'b1,
               mk_span(16'h7FFF, 16'h800F, 16'h8007, 8'd3, 1'b1)),
      row_step(EXP_SPAN, 16'hFFFF, 16'h8000, 10'd8, 1'b0,
               mk_span(16'hFFFF, 16'd15, 16'h8008, 8'd3, 1'b0)),
      row_step(EXP_MODEL, 16'h8000, 16'h0000, 10'd3, 1'b1, '0),
      cfg_step(REG_HEIGHT, 11'd1024),
      cfg_step(REG_PEN, 11'h7FF),
      row_step(EXP_SPAN, 16'h0000, 16'h0000, 10'd0, 1'b0,
               mk_span(16'd512, 16'd512, 16'd0, 8'd255, 1'b0)),
      row_step(EXP_SPAN, 16'h0000, 16'h0000, 10'd512, 1'b1,
               mk_span(16'd0, 16'd1024, 16'd512, 8'd255, 1'b1)),
      row_step(EXP_SPAN, 16'h0000, 16'h0000, 10'd1023, 1'b0,
               mk_span(16'd481, 16'd543, 16'd1023, 8'd255, 1'b0)),
      row_step(EXP_MODEL, 16'h5A5A, 16'hA5A5, 10'h155, 1'b1, '0),
      row_step(EXP_MODEL, 16'hA5A5, 16'h5A5A, 10'h2AA, 1'b0, '0),
      cfg_step(REG_HEIGHT, 11'd0),
      row_step(EXP_NONE, 16'h0000, 16'h0000, 10'd0, 1'b1, '0),
      cfg_step(REG_HEIGHT, 11'd1),
      cfg_step(REG_PEN, 11'd0),
      row_step(EXP_SPAN, 16'h0000, 16'h0000, 10'd0, 1'b1, mk_span(16'd1, 16'd1, 16'd0, 8'd0, 1'b1)),
      row_step(EXP_NONE, 16'h0000, 16'h0000, 10'd1, 1'b0, '0),
      cfg_step(REG_HEIGHT, 11'd2),
      row_step(EXP_MODEL, 16'd100, 16'd200, 10'd0, 1'b0, '0),
      row_step(EXP_MODEL, 16'd100, 16'd200, 10'd1, 1'b1, '0),
      cfg_step(REG_HEIGHT, 11'd2047),
      cfg_step(REG_UNUSED_A, 11'd5),
      cfg_step(REG_UNUSED_B, 11'h7FF),
      row_step(EXP_SPAN, 16'h0000, 16'h0000, 10'd8, 1'b0, mk_span(16'd0, 16'd16, 16'd8, 8'd0, 1'b0)),
      cfg_step(REG_HEIGHT, 11'd1025),
      row_step(EXP_NONE, 16'h0000, 16'h0000, 10'd16, 1'b0, '0),
      cfg_step(REG_HEIGHT, 11'd1023),
      row_step(EXP_MODEL, 16'h0123, 16'h0000, 10'd1022, 1'b1, '0),
      row_step(EXP_MODEL, 16'hFFFF, 16'h7FFF, 10'd0, 1'b0, '0)
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDir; i++) begin
      if (dir_tbl[i].op == DIR_CFG) begin
        if (i == 0 || dir_tbl[i-1].op != DIR_CFG) wait_for_idle();
        write_reg(dir_tbl[i].idx, dir_tbl[i].data,
                  (i + 1 == NumDir) || (dir_tbl[(i + 1) % NumDir].op != DIR_CFG));
      end else begin
        send_row(dir_tbl[i].src, dir_tbl[i].left, dir_tbl[i].top, dir_tbl[i].row,
                 dir_tbl[i].sel, dir_tbl[i].span, pick_gap(30));
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_for_idle();
      case (p)
        0:       h_data = 11'd1024;
        1:       h_data = 11'd1;
        2:       h_data = 11'd2;
        3:       h_data = 11'd1023;
        4:       h_data = 11'd2047;
        default: h_data = CfgDataW'($urandom_range(1, 2047));
      endcase
      case (p)
        0:       pen_data = 11'h0FF;
        1:       pen_data = 11'h000;
        default: pen_data = CfgDataW'($urandom);
      endcase
      write_reg(REG_HEIGHT, h_data, 1'b0);
      write_reg(REG_PEN, pen_data, 1'b0);
      write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, CfgDataW'($urandom), 1'b1);

      // no idling in the closing phases
      if (p >= NumPhases - 2) idle_pct = 0;
      else idle_pct = 25 * int'($urandom_range(0, 2));

      sent = 0;
      while (sent < SpansPerPhase) begin
        if (cfg_height == 0 || $urandom_range(0, 9) == 0) row = RowW'($urandom);
        else row = RowW'($urandom_range(0, cfg_height - 1));
        if (row < cfg_height) sent++;
        send_row(EXP_MODEL, pick_coord(), pick_coord(), row, 1'($urandom), '0,
                 pick_gap(idle_pct));
        if (p < NumPhases - 2 && $urandom_range(0, 63) == 0) wait_for_idle();
      end
    end

    wait_for_idle();
    if (n_errors == 0 && span_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
